// File: design/oanc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oanc_pkg
// types, register codes and constants of the obstacle avoiding nav controller
// ----------------------------------------------------------------------------
package oanc_pkg;

    localparam int AVG_SAMPLES_DEF = 3;

    localparam int DIST_W  = 16;
    localparam int TICKS_W = 8;
    localparam int LED_W   = 4;

    // apb side
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        CFG_STOP_DIST   = 3'd0,
        CFG_OBST_DIST   = 3'd1,
        CFG_CLEAR_FRONT = 3'd2,
        CFG_OPEN_RIGHT  = 3'd3,
        CFG_LED_NEAR    = 3'd4,
        CFG_LED_MID     = 3'd5,
        CFG_LED_FAR     = 3'd6
    } t_cfg_idx;

    localparam logic [DIST_W-1:0] RST_STOP_DIST   = 16'd20;
    localparam logic [DIST_W-1:0] RST_OBST_DIST   = 16'd70;
    localparam logic [DIST_W-1:0] RST_CLEAR_FRONT = 16'd100;
    localparam logic [DIST_W-1:0] RST_OPEN_RIGHT  = 16'd100;
    localparam logic [DIST_W-1:0] RST_LED_NEAR    = 16'd15;
    localparam logic [DIST_W-1:0] RST_LED_MID     = 16'd30;
    localparam logic [DIST_W-1:0] RST_LED_FAR     = 16'd70;

    typedef struct packed {
        logic [DIST_W-1:0] stop_dist;
        logic [DIST_W-1:0] obst_dist;
        logic [DIST_W-1:0] clear_front;
        logic [DIST_W-1:0] open_right;
        logic [DIST_W-1:0] led_near;
        logic [DIST_W-1:0] led_mid;
        logic [DIST_W-1:0] led_far;
    } t_cfg;

    typedef enum logic [1:0] {
        NAV_FORWARD = 2'd0,
        NAV_DECIDE  = 2'd1,
        NAV_TURN    = 2'd2
    } t_nav_state;

    typedef enum logic [1:0] {
        DRV_FORWARD = 2'd0,
        DRV_STOP    = 2'd1,
        DRV_RIGHT   = 2'd2,
        DRV_LEFT    = 2'd3
    } t_drive;

    localparam logic [LED_W-1:0] LED_NEAR_ZONE = 4'b0001;
    localparam logic [LED_W-1:0] LED_MID_ZONE  = 4'b0010;
    localparam logic [LED_W-1:0] LED_FAR_ZONE  = 4'b0100;
    localparam logic [LED_W-1:0] LED_OPEN_ZONE = 4'b1000;

    // sample = (ticks*256 - 200) / 58, by reciprocal 2^22 / 58 rounded up
    localparam logic [DIST_W-1:0] SAMPLE_OFFSET     = 16'd200;
    localparam int                SAMPLE_RECIP_W    = 17;
    localparam logic [16:0]       SAMPLE_RECIP      = 17'd72316;
    localparam int                SAMPLE_SHIFT      = 22;
    localparam int                SAMPLE_Q_W        = 11;
    localparam logic [DIST_W-1:0] SAMPLE_ZERO_TICKS = 16'hFFFD;

endpackage

// File: design/oanc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oanc_in_if
// poll channel: echo level, echo tick count and front distance
// ----------------------------------------------------------------------------
interface oanc_in_if;
    import oanc_pkg::*;

    logic               valid;
    logic               ready;
    logic               echo_level;
    logic [TICKS_W-1:0] echo_ticks;
    logic [DIST_W-1:0]  front_distance;

    modport source (output valid, output echo_level, output echo_ticks,
                    output front_distance, input ready);
    modport sink   (input valid, input echo_level, input echo_ticks,
                    input front_distance, output ready);
endinterface

// File: design/oanc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oanc_out_if
// result channel: motor drive, zone leds, right distance, nav state, echo done
// ----------------------------------------------------------------------------
interface oanc_out_if;
    import oanc_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        motor_drive;
    logic [LED_W-1:0]  led_pattern;
    logic [DIST_W-1:0] right_distance_out;
    logic [1:0]        nav_state_out;
    logic              echo_done;

    modport source (output valid, output motor_drive, output led_pattern,
                    output right_distance_out, output nav_state_out,
                    output echo_done, input ready);
    modport sink   (input valid, input motor_drive, input led_pattern,
                    input right_distance_out, input nav_state_out,
                    input echo_done, output ready);
endinterface

// File: design/oanc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oanc_cfg_regs
// apb register file holding the distance thresholds and led band limits
// ----------------------------------------------------------------------------
module oanc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [oanc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [oanc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [oanc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output oanc_pkg::t_cfg                  o_cfg
);
    import oanc_pkg::*;

    t_cfg              r_cfg;
    t_cfg              n_cfg;
    logic [2:0]        w_idx;
    logic              w_wr;
    logic [DIST_W-1:0] w_wdata;
    logic [DIST_W-1:0] w_rdata;

    assign w_idx   = paddr[4:2];
    assign w_wr    = psel && penable && pwrite;
    assign w_wdata = pwdata[DIST_W-1:0];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                CFG_STOP_DIST:   n_cfg.stop_dist   = w_wdata;
                CFG_OBST_DIST:   n_cfg.obst_dist   = w_wdata;
                CFG_CLEAR_FRONT: n_cfg.clear_front = w_wdata;
                CFG_OPEN_RIGHT:  n_cfg.open_right  = w_wdata;
                CFG_LED_NEAR:    n_cfg.led_near    = w_wdata;
                CFG_LED_MID:     n_cfg.led_mid     = w_wdata;
                CFG_LED_FAR:     n_cfg.led_far     = w_wdata;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            CFG_STOP_DIST:   w_rdata = r_cfg.stop_dist;
            CFG_OBST_DIST:   w_rdata = r_cfg.obst_dist;
            CFG_CLEAR_FRONT: w_rdata = r_cfg.clear_front;
            CFG_OPEN_RIGHT:  w_rdata = r_cfg.open_right;
            CFG_LED_NEAR:    w_rdata = r_cfg.led_near;
            CFG_LED_MID:     w_rdata = r_cfg.led_mid;
            CFG_LED_FAR:     w_rdata = r_cfg.led_far;
            default:         w_rdata = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(w_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_dist   <= RST_STOP_DIST;
            r_cfg.obst_dist   <= RST_OBST_DIST;
            r_cfg.clear_front <= RST_CLEAR_FRONT;
            r_cfg.open_right  <= RST_OPEN_RIGHT;
            r_cfg.led_near    <= RST_LED_NEAR;
            r_cfg.led_mid     <= RST_LED_MID;
            r_cfg.led_far     <= RST_LED_FAR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: design/obstacle_avoid_nav_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_avoid_nav_controller_unit
// right echo sampling and averaging, front zone leds, forward/decide/turn drive
//
//   channel   dir  handshake       carries
//   i_in      in   valid / ready   echo_level, echo_ticks, front_distance
//   o_out     out  valid / ready   motor_drive, led_pattern, right_distance_out,
//                                  nav_state_out, echo_done
//   apb       in   psel / penable  threshold and led band registers
//
// two register stages: the input register holds the tick count already turned
// into a sample, the result register takes the item after the averaging and
// state update. one transaction per cycle while the result channel is not stalled.
// the result register and the input register each act as a buffer, so a
// stalled output holds up the input only once both are full.
// synchronous reset clears the state, samples and valids, presets thresholds.
// ----------------------------------------------------------------------------
module obstacle_avoid_nav_controller_unit #(
    parameter int AVG_SAMPLES = oanc_pkg::AVG_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    oanc_in_if.sink                         i_in,
    oanc_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [oanc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [oanc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [oanc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import oanc_pkg::*;

    localparam int IDX_W  = (AVG_SAMPLES > 2) ? $clog2(AVG_SAMPLES) : 1;
    localparam int SUM_W  = DIST_W + $clog2(AVG_SAMPLES);
    localparam int DIV_SH = SUM_W + $clog2(AVG_SAMPLES);
    localparam int RECIP_W = DIV_SH + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((2 ** DIV_SH) + AVG_SAMPLES - 1) / AVG_SAMPLES);
    localparam logic [IDX_W:0]   IDX_LIMIT = (IDX_W + 1)'(AVG_SAMPLES);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(AVG_SAMPLES - 1);

    t_cfg w_cfg;

    oanc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic              r_in_vld;
    logic              r_in_level;
    logic [DIST_W-1:0] r_in_sample;
    logic [DIST_W-1:0] r_in_front;

    // handshake
    logic w_out_free;
    logic w_proc;
    logic w_take;

    assign w_out_free = !o_out.valid || o_out.ready;
    assign w_proc     = r_in_vld && w_out_free;
    assign i_in.ready = !r_in_vld || w_out_free;
    assign w_take     = i_in.valid && i_in.ready;

    // tick count to sample at the input side
    logic [DIST_W-1:0]                w_num;
    logic [DIST_W+SAMPLE_RECIP_W-1:0] w_sprod;
    logic [DIST_W-1:0]                w_sample;

    assign w_num    = {i_in.echo_ticks, 8'h00} - SAMPLE_OFFSET;
    assign w_sprod  = w_num * SAMPLE_RECIP;
    assign w_sample = (i_in.echo_ticks == '0) ? SAMPLE_ZERO_TICKS
                    : DIST_W'(w_sprod[SAMPLE_SHIFT +: SAMPLE_Q_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_level  <= i_in.echo_level;
            r_in_sample <= w_sample;
            r_in_front  <= i_in.front_distance;
        end
    end

    // state
    logic              r_armed,  n_armed;
    logic [IDX_W-1:0]  r_idx,    n_idx;
    logic [DIST_W-1:0] r_samples [AVG_SAMPLES];
    logic [DIST_W-1:0] r_rdist,  n_rdist;
    t_nav_state        r_nav,    n_nav;
    t_drive            r_drive,  n_drive;
    logic [LED_W-1:0]  r_led,    n_led;
    logic              n_done;

    logic [IDX_W-1:0]       w_idx_eff;
    logic                   w_consume;
    logic [SUM_W-1:0]       w_sum;
    logic [SUM_W+RECIP_W-1:0] w_aprod;
    logic [DIST_W-1:0]      w_avg;

    assign w_consume = w_proc && !r_in_level && r_armed;
    // an out of range slot restarts at slot zero
    assign w_idx_eff = ({1'b0, r_idx} >= IDX_LIMIT) ? '0 : r_idx;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < AVG_SAMPLES; k++) begin
            w_sum = w_sum + SUM_W'((w_idx_eff == IDX_W'(k)) ? r_in_sample : r_samples[k]);
        end
    end

    assign w_aprod = w_sum * AVG_RECIP;
    assign w_avg   = w_aprod[DIV_SH +: DIST_W];

    always_comb begin
        n_armed = r_armed;
        n_idx   = r_idx;
        n_rdist = r_rdist;
        n_nav   = r_nav;
        n_drive = r_drive;
        n_led   = r_led;
        n_done  = 1'b0;
        if (w_proc) begin
            if (r_in_level) begin
                n_armed = 1'b1;
            end else if (r_armed) begin
                n_armed = 1'b0;
                n_done  = 1'b1;
                if (w_idx_eff == IDX_LAST) begin
                    n_rdist = w_avg;
                    n_idx   = '0;
                end else begin
                    n_idx = w_idx_eff + 1'b1;
                end
            end

            if (r_in_front != '0 && n_rdist != '0) begin
                // band edges are exclusive, a front on an edge keeps the leds
                priority if (r_in_front < w_cfg.led_near) begin
                    n_led = LED_NEAR_ZONE;
                end else if (r_in_front > w_cfg.led_near && r_in_front < w_cfg.led_mid) begin
                    n_led = LED_MID_ZONE;
                end else if (r_in_front > w_cfg.led_mid && r_in_front < w_cfg.led_far) begin
                    n_led = LED_FAR_ZONE;
                end else if (r_in_front > w_cfg.led_far) begin
                    n_led = LED_OPEN_ZONE;
                end else begin
                    n_led = r_led;
                end

                unique case (r_nav)
                    NAV_FORWARD: begin
                        n_drive = DRV_FORWARD;
                        if (r_in_front < w_cfg.obst_dist) begin
                            n_nav   = NAV_DECIDE;
                            n_drive = DRV_STOP;
                        end
                    end
                    NAV_DECIDE: begin
                        n_nav   = NAV_TURN;
                        n_drive = (n_rdist > w_cfg.open_right) ? DRV_RIGHT : DRV_LEFT;
                    end
                    NAV_TURN: begin
                        if (r_in_front > w_cfg.clear_front) begin
                            n_nav   = NAV_FORWARD;
                            n_drive = DRV_FORWARD;
                        end
                    end
                    default: begin
                        n_nav = r_nav;
                    end
                endcase

                if (r_in_front < w_cfg.stop_dist) begin
                    n_drive = DRV_STOP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_idx   <= '0;
            r_rdist <= '0;
            r_nav   <= NAV_FORWARD;
            r_drive <= DRV_FORWARD;
            r_led   <= '0;
        end else begin
            r_armed <= n_armed;
            r_idx   <= n_idx;
            r_rdist <= n_rdist;
            r_nav   <= n_nav;
            r_drive <= n_drive;
            r_led   <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AVG_SAMPLES; k++) begin
                r_samples[k] <= '0;
            end
        end else if (w_consume) begin
            r_samples[w_idx_eff] <= r_in_sample;
        end
    end

    // result register
    logic              r_out_vld;
    t_drive            r_out_drive;
    logic [LED_W-1:0]  r_out_led;
    logic [DIST_W-1:0] r_out_rdist;
    t_nav_state        r_out_nav;
    logic              r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_drive <= n_drive;
            r_out_led   <= n_led;
            r_out_rdist <= n_rdist;
            r_out_nav   <= n_nav;
            r_out_done  <= n_done;
        end
    end

    assign o_out.valid              = r_out_vld;
    assign o_out.motor_drive        = r_out_drive;
    assign o_out.led_pattern        = r_out_led;
    assign o_out.right_distance_out = r_out_rdist;
    assign o_out.nav_state_out      = r_out_nav;
    assign o_out.echo_done          = r_out_done;

endmodule

// File: sim/tb_obstacle_avoid_nav_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_obstacle_avoid_nav_controller_unit
// self-checking bench: a short directed table, then random echo pulses with
// random front distances under several threshold settings and idling patterns,
// each result checked field by field against its table entry or a cycle-free predictor
// ----------------------------------------------------------------------------
module tb_obstacle_avoid_nav_controller_unit;
    import oanc_pkg::*;

    localparam int NUM_REGS        = int'(CFG_LED_FAR) + 1;
    localparam int ECHO_SCALE      = 256;
    localparam int ECHO_OFFSET     = 200;
    localparam int ECHO_DIVISOR    = 58;
    localparam int SETTLE_CYCLES   = 6;
    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_POLLS     = 190;

    typedef struct packed {
        t_drive            drive;
        logic [LED_W-1:0]  led;
        logic [DIST_W-1:0] right;
        t_nav_state        nav;
        logic              done;
    } t_nav_response;

    typedef struct packed {
        logic               level;
        logic [TICKS_W-1:0] ticks;
        logic [DIST_W-1:0]  front;
        logic               typed;
        t_nav_response      want;
    } t_poll;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    oanc_in_if  in_ch ();
    oanc_out_if out_ch ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    obstacle_avoid_nav_controller_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of thresholds and state
    t_cfg              thr;
    logic              echo_armed = 1'b0;
    logic [1:0]        slot_idx   = 2'd0;
    logic [DIST_W-1:0] right_slots [AVG_SAMPLES_DEF];
    logic [DIST_W-1:0] avg_right  = '0;
    t_nav_state        nav_q      = NAV_FORWARD;
    t_drive            drive_q    = DRV_FORWARD;
    logic [LED_W-1:0]  led_q      = '0;

    t_nav_response     pending_responses [$];
    t_poll             directed_polls [$];
    t_poll             cur_poll;
    logic [DIST_W-1:0] cfg_plan [NUM_REGS];

    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    int   polls_sent   = 0;
    int   error_cnt    = 0;
    int   idle_cycles  = 0;
    logic rx_hold      = 1'b0;
    event hold_off_ev;

    function automatic logic [DIST_W-1:0] echo_to_cm(logic [TICKS_W-1:0] ticks);
        int num;
        num = int'(ticks) * ECHO_SCALE - ECHO_OFFSET;
        // signed division truncates toward zero, low 16 bits kept
        return DIST_W'(num / ECHO_DIVISOR);
    endfunction

    function automatic t_nav_response compute_nav_response(t_poll p);
        t_nav_response r;
        int slot;
        int sum;
        r.done = 1'b0;
        if (p.level) begin
            echo_armed = 1'b1;
        end else if (echo_armed) begin
            echo_armed = 1'b0;
            r.done = 1'b1;
            slot = slot_idx;
            if (slot >= AVG_SAMPLES_DEF) slot = 0;
            right_slots[slot] = echo_to_cm(p.ticks);
            slot++;
            if (slot == AVG_SAMPLES_DEF) begin
                sum = 0;
                for (int i = 0; i < AVG_SAMPLES_DEF; i++) sum += right_slots[i];
                avg_right = DIST_W'(sum / AVG_SAMPLES_DEF);
                slot = 0;
            end
            slot_idx = 2'(slot);
        end
        if (p.front != '0 && avg_right != '0) begin
            // nearest band first; a front on a band edge leaves the leds alone
            if (p.front < thr.led_near) begin
                led_q = LED_NEAR_ZONE;
            end else if (p.front > thr.led_near && p.front < thr.led_mid) begin
                led_q = LED_MID_ZONE;
            end else if (p.front > thr.led_mid && p.front < thr.led_far) begin
                led_q = LED_FAR_ZONE;
            end else if (p.front > thr.led_far) begin
                led_q = LED_OPEN_ZONE;
            end
            case (nav_q)
                NAV_FORWARD: begin
                    drive_q = DRV_FORWARD;
                    if (p.front < thr.obst_dist) begin
                        nav_q   = NAV_DECIDE;
                        drive_q = DRV_STOP;
                    end
                end
                NAV_DECIDE: begin
                    nav_q   = NAV_TURN;
                    drive_q = (avg_right > thr.open_right) ? DRV_RIGHT : DRV_LEFT;
                end
                NAV_TURN: begin
                    if (p.front > thr.clear_front) begin
                        nav_q   = NAV_FORWARD;
                        drive_q = DRV_FORWARD;
                    end
                end
                default: ;
            endcase
            if (p.front < thr.stop_dist) drive_q = DRV_STOP;
        end
        r.drive = drive_q;
        r.led   = led_q;
        r.right = avg_right;
        r.nav   = nav_q;
        return r;
    endfunction

    task automatic log_failure(string msg);
        error_cnt++;
        $display("mismatch: %s", msg);
    endtask

    function automatic logic [DIST_W-1:0] pick_front();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8) return '0;
        // close to a threshold, edges and one either side
        if (sel < 48) return cfg_plan[$urandom_range(NUM_REGS-1)] +
                             DIST_W'($urandom_range(2)) - 16'd1;
        if (sel < 80) return DIST_W'($urandom_range(200));
        return DIST_W'($urandom);
    endfunction

    function automatic logic [TICKS_W-1:0] pick_ticks();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) return '0;
        // short echoes keep the right distance around the turn threshold
        if (sel < 55) return TICKS_W'($urandom_range(45));
        return TICKS_W'($urandom);
    endfunction

    task automatic add_poll(logic level, logic [TICKS_W-1:0] ticks,
                            logic [DIST_W-1:0] front);
        t_poll p;
        p       = '0;
        p.level = level;
        p.ticks = ticks;
        p.front = front;
        directed_polls.push_back(p);
    endtask

    task automatic add_typed(logic level, logic [TICKS_W-1:0] ticks,
                             logic [DIST_W-1:0] front, t_drive drive,
                             logic [LED_W-1:0] led, logic [DIST_W-1:0] right,
                             t_nav_state nav, logic done);
        t_poll p;
        p            = '0;
        p.level      = level;
        p.ticks      = ticks;
        p.front      = front;
        p.typed      = 1'b1;
        p.want.drive = drive;
        p.want.led   = led;
        p.want.right = right;
        p.want.nav   = nav;
        p.want.done  = done;
        directed_polls.push_back(p);
    endtask

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_poll(t_poll p);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.echo_level     <= p.level;
        in_ch.echo_ticks     <= p.ticks;
        in_ch.front_distance <= p.front;
        cur_poll             <= p;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        polls_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(t_cfg_idx idx, logic [DIST_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            CFG_STOP_DIST:   thr.stop_dist   = val;
            CFG_OBST_DIST:   thr.obst_dist   = val;
            CFG_CLEAR_FRONT: thr.clear_front = val;
            CFG_OPEN_RIGHT:  thr.open_right  = val;
            CFG_LED_NEAR:    thr.led_near    = val;
            CFG_LED_MID:     thr.led_mid     = val;
            CFG_LED_FAR:     thr.led_far     = val;
            default: ;
        endcase
    endtask

    task automatic program_thresholds();
        for (int r = 0; r < NUM_REGS; r++) apb_write(t_cfg_idx'(r), cfg_plan[r]);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic plan_random(int full_pct);
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_plan[r] = ($urandom_range(99) < full_pct) ? DIST_W'($urandom)
                                                           : DIST_W'($urandom_range(150));
        end
    endtask

    task automatic plan_uniform(logic [DIST_W-1:0] v);
        for (int r = 0; r < NUM_REGS; r++) cfg_plan[r] = v;
    endtask

    task automatic run_phase(int n, int tx_pct, int rx_pct, logic pressure);
        t_poll p;
        int    start;
        int    highs;
        int    lows;
        logic  held;
        logic  paused;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start  = polls_sent;
        held   = 1'b0;
        paused = 1'b0;
        p      = '0;
        while (polls_sent - start < n) begin
            if (pressure && !held && polls_sent - start >= n / 3) begin
                // sink holds off while we keep offering, so the input backs up
                held = 1'b1;
                -> hold_off_ev;
            end
            if (pressure && !paused && polls_sent - start >= 2 * n / 3) begin
                paused = 1'b1;
                wait_drained();
            end
            if ($urandom_range(99) < 12) begin
                p.level = 1'($urandom);
                p.ticks = TICKS_W'($urandom);
                p.front = ($urandom_range(1)) ? DIST_W'($urandom) : pick_front();
                send_poll(p);
            end else begin
                // one echo pulse: a few high polls, then the falling edge
                highs = $urandom_range(1, 3);
                repeat (highs) begin
                    p.level = 1'b1;
                    p.ticks = TICKS_W'($urandom);
                    p.front = pick_front();
                    send_poll(p);
                end
                p.level = 1'b0;
                p.ticks = pick_ticks();
                p.front = pick_front();
                send_poll(p);
                lows = $urandom_range(0, 2);
                repeat (lows) begin
                    p.level = 1'b0;
                    p.ticks = TICKS_W'($urandom);
                    p.front = pick_front();
                    send_poll(p);
                end
            end
        end
        wait_drained();
    endtask

    // accepted poll transaction: advance the predictor
    always @(posedge i_clk) begin : poll_capture
        t_nav_response r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            r = compute_nav_response(cur_poll);
            if (cur_poll.typed) r = cur_poll.want;
            pending_responses.push_back(r);
        end
    end

    always @(posedge i_clk) begin : response_check
        t_nav_response want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_responses.size() == 0) begin
                log_failure("result transaction with nothing pending");
            end else begin
                want = pending_responses.pop_front();
                if (out_ch.motor_drive !== want.drive)
                    log_failure($sformatf("motor_drive got %0d want %0d",
                                          out_ch.motor_drive, want.drive));
                if (out_ch.led_pattern !== want.led)
                    log_failure($sformatf("led_pattern got %0h want %0h",
                                          out_ch.led_pattern, want.led));
                if (out_ch.right_distance_out !== want.right)
                    log_failure($sformatf("right_distance_out got %0d want %0d",
                                          out_ch.right_distance_out, want.right));
                if (out_ch.nav_state_out !== want.nav)
                    log_failure($sformatf("nav_state_out got %0d want %0d",
                                          out_ch.nav_state_out, want.nav));
                if (out_ch.echo_done !== want.done)
                    log_failure($sformatf("echo_done got %0d want %0d",
                                          out_ch.echo_done, want.done));
            end
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        forever begin
            @(hold_off_ev);
            rx_hold <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.echo_level     = 1'b0;
        in_ch.echo_ticks     = '0;
        in_ch.front_distance = '0;
        out_ch.ready         = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        cur_poll             = '0;
        thr = '{RST_STOP_DIST, RST_OBST_DIST, RST_CLEAR_FRONT, RST_OPEN_RIGHT,
                RST_LED_NEAR, RST_LED_MID, RST_LED_FAR};
        for (int i = 0; i < AVG_SAMPLES_DEF; i++) right_slots[i] = '0;

        // reset thresholds; three ticks-zero echoes give 65533 each
        add_typed(1'b0, 8'd0,   16'd0,     DRV_FORWARD, '0, 16'd0, NAV_FORWARD, 1'b0);
        add_typed(1'b1, 8'd255, 16'd65535, DRV_FORWARD, '0, 16'd0, NAV_FORWARD, 1'b0);
        add_typed(1'b0, 8'd0,   16'd65535, DRV_FORWARD, '0, 16'd0, NAV_FORWARD, 1'b1);
        add_typed(1'b0, 8'd0,   16'd0,     DRV_FORWARD, '0, 16'd0, NAV_FORWARD, 1'b0);
        add_typed(1'b1, 8'd0,   16'd0,     DRV_FORWARD, '0, 16'd0, NAV_FORWARD, 1'b0);
        add_typed(1'b0, 8'd0,   16'd0,     DRV_FORWARD, '0, 16'd0, NAV_FORWARD, 1'b1);
        add_typed(1'b1, 8'd0,   16'd0,     DRV_FORWARD, '0, 16'd0, NAV_FORWARD, 1'b0);
        add_typed(1'b0, 8'd0,   16'd0,     DRV_FORWARD, '0, 16'd65533, NAV_FORWARD, 1'b1);
        add_typed(1'b1, 8'd255, 16'd65535, DRV_FORWARD, LED_OPEN_ZONE, 16'd65533,
                  NAV_FORWARD, 1'b0);
        // band edges, each band, every nav transition and the stop override
        add_poll(1'b0, 8'd255, 16'd15);
        add_poll(1'b1, 8'd128, 16'd14);
        add_poll(1'b0, 8'd1,   16'd30);
        add_poll(1'b1, 8'd0,   16'd29);
        add_poll(1'b0, 8'd2,   16'd70);
        add_poll(1'b1, 8'd0,   16'd50);
        add_poll(1'b0, 8'd77,  16'd101);
        add_poll(1'b0, 8'd0,   16'd1);
        add_poll(1'b1, 8'd170, 16'd100);
        add_poll(1'b0, 8'd85,  16'd65535);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_polls[i]) send_poll(directed_polls[i]);
        wait_drained();

        cfg_plan[CFG_STOP_DIST]   = RST_STOP_DIST;
        cfg_plan[CFG_OBST_DIST]   = RST_OBST_DIST;
        cfg_plan[CFG_CLEAR_FRONT] = RST_CLEAR_FRONT;
        cfg_plan[CFG_OPEN_RIGHT]  = RST_OPEN_RIGHT;
        cfg_plan[CFG_LED_NEAR]    = RST_LED_NEAR;
        cfg_plan[CFG_LED_MID]     = RST_LED_MID;
        cfg_plan[CFG_LED_FAR]     = RST_LED_FAR;
        program_thresholds();
        run_phase(PHASE_POLLS, 0, 0, 1'b1);

        plan_random(0);
        program_thresholds();
        run_phase(PHASE_POLLS, 81, 0, 1'b0);

        plan_uniform('0);
        program_thresholds();
        run_phase(PHASE_POLLS, 0, 81, 1'b0);

        plan_uniform('1);
        program_thresholds();
        run_phase(PHASE_POLLS, 30, 30, 1'b0);

        plan_random(25);
        program_thresholds();
        run_phase(PHASE_POLLS, 30, 30, 1'b0);

        plan_random(0);
        program_thresholds();
        run_phase(PHASE_POLLS, 0, 81, 1'b0);

        if (pending_responses.size() != 0) log_failure("results still pending at end");
        if (error_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
design/oanc_pkg.sv
design/oanc_in_if.sv
design/oanc_out_if.sv
design/oanc_cfg_regs.sv
design/obstacle_avoid_nav_controller_unit.sv
sim/tb_obstacle_avoid_nav_controller_unit.sv
